// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the stable priority process queue.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package spq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 32;
    localparam int PRIO_W      = 8;
    localparam int ID_W        = 5;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Operation codes carried in the request.
    typedef enum logic [1:0] {
        OP_INSERT      = 2'd0,
        OP_REMOVE_HEAD = 2'd1,
        OP_REMOVE_ID   = 2'd2
    } op_e;

    // Status codes reported with every result.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_DUP      = 3'd4
    } status_e;

    // Action broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_act_e;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_e;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ID_W-1:0]   entry_id;
        logic [PRIO_W-1:0] entry_priority;
    } req_t;

    typedef struct packed {
        status_e           status;
        logic              removed_valid;
        logic [ID_W-1:0]   removed_id;
        logic [PRIO_W-1:0] removed_priority;
        logic              head_valid;
        logic [ID_W-1:0]   head_id;
        logic [PRIO_W-1:0] head_priority;
        logic [CNT_W-1:0]  entry_count;
    } res_t;

    // Contents of one queue slot.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    // Command shared by all cells for one operation.
    typedef struct packed {
        cell_act_e         act;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [IDX_W-1:0]  pos;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and shifts to/from neighbors.
// Depends on spq_pkg for the slot and command types.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire cell_cmd_t        cmd,
    input  wire slot_t            left,
    input  wire slot_t            right,
    output slot_t                 slot,
    output slot_t                 slot_next,
    output logic                  match
);

    logic                      valid_reg;
    logic [ID_W+PRIO_W-1:0]    data_reg;
    logic                      left_shift;
    logic                      take_new;
    logic                      own_lower;
    logic                      left_ok;

    assign slot.valid = valid_reg;
    assign slot.id    = data_reg[ID_W+PRIO_W-1:PRIO_W];
    assign slot.prio  = data_reg[PRIO_W-1:0];

    // The id compare feeds duplicate detection and remove-by-id.
    assign match = valid_reg && (slot.id == cmd.id);

    // Insert placement: entries of lower priority move one slot toward the tail.
    assign left_shift = left.valid && (left.prio < cmd.prio);
    assign own_lower  = !valid_reg || (slot.prio < cmd.prio);
    assign left_ok    = left.valid || (cell_index == '0);
    assign take_new   = !left_shift && own_lower && left_ok;

    // Next slot content for the broadcast action.
    always_comb
    begin
        slot_next = slot;
        case (cmd.act)
            CELL_INSERT:
            begin
                if (left_shift)
                begin
                    slot_next = left;
                end
                else if (take_new)
                begin
                    slot_next.valid = 1'b1;
                    slot_next.id    = cmd.id;
                    slot_next.prio  = cmd.prio;
                end
            end
            CELL_REMOVE:
            begin
                if (cell_index >= cmd.pos)
                begin
                    slot_next = right;
                end
            end
            default:
            begin
                slot_next = slot;
            end
        endcase
    end

    // Valid bit is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= slot_next.valid;
        end
    end

    // Slot payload needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= {slot_next.id, slot_next.prio};
    end

endmodule

`default_nettype wire

// ===== rtl/stable_priority_process_queue_unit.sv =====
// Top level of the stable priority process queue: controller and the chain of slot cells.
// Depends on spq_pkg and spq_cell.
// A request accepted while idle is executed in the next cycle; its result is registered
// at the end of that cycle and shown on the result port with done high for one cycle.
// Busy covers the execute cycle of the chain pass, so a new request is taken only while idle.
// Reset empties the queue and clears done; the receiver cannot stall results.
`default_nettype none

module stable_priority_process_queue_unit
    import spq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output logic      done,
    output res_t      result
);

    state_e             state_reg;
    state_e             state_next;
    req_t               req_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    res_t               result_reg;
    res_t               result_next;
    logic               done_reg;
    logic               done_next;
    cell_cmd_t          cmd;
    slot_t              cell_slot [QUEUE_DEPTH];
    slot_t              cell_next [QUEUE_DEPTH];
    slot_t              cell_left [QUEUE_DEPTH];
    slot_t              cell_right[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] match;
    logic               found;
    logic [IDX_W-1:0]   match_pos;
    slot_t              match_slot;

    assign busy   = (state_reg == S_EXEC);
    assign done   = done_reg;
    assign result = result_reg;

    // Cell chain: each cell sees its left and right neighbors.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign cell_left[i] = '0;
        end
        else
        begin : g_mid
            assign cell_left[i] = cell_slot[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign cell_right[i] = '0;
        end
        else
        begin : g_inner
            assign cell_right[i] = cell_slot[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .cmd        (cmd),
            .left       (cell_left[i]),
            .right      (cell_right[i]),
            .slot       (cell_slot[i]),
            .slot_next  (cell_next[i]),
            .match      (match[i])
        );
    end

    // Ids are unique, so the match vector is one-hot or zero: encode by OR.
    always_comb
    begin
        match_pos  = '0;
        match_slot = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (match[i])
            begin
                match_pos  = match_pos | IDX_W'(i);
                match_slot = match_slot | cell_slot[i];
            end
        end
    end

    assign found = |match;

    // Next state, cell command and result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        cmd.act     = CELL_HOLD;
        cmd.id      = req_reg.entry_id;
        cmd.prio    = req_reg.entry_priority;
        cmd.pos     = '0;
        result_next = result_reg;
        result_next.status           = ST_OK;
        result_next.removed_valid    = 1'b0;
        result_next.removed_id       = '0;
        result_next.removed_priority = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (req_reg.opcode)
                    OP_INSERT:
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            result_next.status = ST_FULL;
                        end
                        else if (found)
                        begin
                            result_next.status = ST_DUP;
                        end
                        else
                        begin
                            cmd.act    = CELL_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_REMOVE_HEAD, OP_REMOVE_ID:
                    begin
                        if (count_reg == '0)
                        begin
                            result_next.status = ST_EMPTY;
                        end
                        else if ((req_reg.opcode == OP_REMOVE_ID) && !found)
                        begin
                            result_next.status = ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.act    = CELL_REMOVE;
                            count_next = count_reg - 1'b1;
                            result_next.removed_valid = 1'b1;
                            if (req_reg.opcode == OP_REMOVE_HEAD)
                            begin
                                cmd.pos = '0;
                                result_next.removed_id       = cell_slot[0].id;
                                result_next.removed_priority = cell_slot[0].prio;
                            end
                            else
                            begin
                                cmd.pos = match_pos;
                                result_next.removed_id       = match_slot.id;
                                result_next.removed_priority = match_slot.prio;
                            end
                        end
                    end
                    default:
                    begin
                        result_next.status = ST_OK;
                    end
                endcase
                // Head and count after the operation.
                result_next.entry_count = count_next;
                result_next.head_valid  = (count_next != '0);
                if (count_next != '0)
                begin
                    result_next.head_id       = cell_next[0].id;
                    result_next.head_priority = cell_next[0].prio;
                end
                else
                begin
                    result_next.head_id       = '0;
                    result_next.head_priority = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

endmodule

`default_nettype wire
